FILE: design/tank_drive_command_shaper_core_defines.svh
// Assertion macros shared by the shaper checker.
`ifndef TANK_DRIVE_COMMAND_SHAPER_CORE_DEFINES_SVH
`define TANK_DRIVE_COMMAND_SHAPER_CORE_DEFINES_SVH

// Same-cycle implication.
`define TDCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TDCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/tdcs_pkg.sv
// Shared types and constants of the tank drive command shaper.
`default_nettype none

package tdcs_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    REG_RAMP_STEP    = 3'd0,
    REG_EMA_WEIGHT   = 3'd1,
    REG_LEFT_GAIN    = 3'd2,
    REG_RIGHT_GAIN   = 3'd3,
    REG_WINDOW_START = 3'd4,
    REG_WINDOW_MAX   = 3'd5,
    REG_DWELL_TIME   = 3'd6,
    REG_REV_THRESH   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  ramp_step;
    logic [15:0] ema_weight;
    logic [15:0] left_gain;
    logic [15:0] right_gain;
    logic [6:0]  window_start;
    logic [6:0]  window_max;
    logic [15:0] dwell_time;
    logic [6:0]  reverse_threshold;
  } cfg_t;

  localparam logic [7:0]  RstRampStep   = 8'd5;
  localparam logic [15:0] RstAlpha      = 16'd0;
  localparam logic [15:0] RstGain       = 16'd16384;
  localparam logic [6:0]  RstWinStart   = 7'd30;
  localparam logic [6:0]  RstWinMax     = 7'd60;
  localparam logic [15:0] RstDwell      = 16'd0;
  localparam logic [6:0]  RstThreshold  = 7'd0;

  // Datapath steps, one per working state of the controller.
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_GATE     = 4'd1,
    OP_EMA_DIFF = 4'd2,
    OP_EMA_MUL  = 4'd3,
    OP_EMA_UPD  = 4'd4,
    OP_GAIN_MUL = 4'd5,
    OP_GAIN_SCL = 4'd6,
    OP_WIN_MUL  = 4'd7,
    OP_DIV_MUL  = 4'd8,
    OP_WIN_FIN  = 4'd9
  } op_t;

  typedef struct packed {
    op_t  op;
    logic wheel;     // 0 left, 1 right
    logic load;      // capture an input word
    logic out_load;  // move results into the output register
  } ctl_t;

  // Command limit and divide-by-100 reciprocal (exact for n < 43699).
  localparam logic signed [7:0] CmdLimit   = 8'sd100;
  localparam logic [12:0]       DivRecip   = 13'd5243;
  localparam int unsigned       DivShift   = 19;
  localparam int unsigned       GainShift  = 30;

  // Saturate a raw target to the command range.
  function automatic logic signed [7:0] clamp_cmd(input logic signed [7:0] v);
    logic signed [7:0] r;
    begin
      r = v;
      if (v > CmdLimit) r = CmdLimit;
      else if (v < -CmdLimit) r = -CmdLimit;
      return r;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/tdcs_ifs.sv
// Valid/ready channel interfaces: tick input, ESC output, register writes.
`default_nettype none

interface tdcs_tick_if;
  logic              valid;
  logic              ready;
  logic [31:0]       now_ms;
  logic signed [7:0] left_target;
  logic signed [7:0] right_target;
  modport source (output valid, output now_ms, output left_target, output right_target,
                  input ready);
  modport sink (input valid, input now_ms, input left_target, input right_target,
                output ready);
endinterface

interface tdcs_esc_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] left_esc;
  logic signed [7:0] right_esc;
  logic              left_dwelling;
  logic              right_dwelling;
  modport source (output valid, output left_esc, output right_esc, output left_dwelling,
                  output right_dwelling, input ready);
  modport sink (input valid, input left_esc, input right_esc, input left_dwelling,
                input right_dwelling, output ready);
endinterface

interface tdcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/tank_drive_command_shaper_core.sv
// Tank drive command shaper: top level.
//
// Channels: tick takes one word per control tick (now_ms, left_target,
// right_target); esc returns one word per tick (left_esc, right_esc and the
// two dwelling flags); cfg writes one register per handshake, index 0..7,
// and is always ready. Write registers only while no tick is in flight.
// The tick channel is ready only while idle, so each tick is worked through
// before the next is taken. Each wheel takes nine steps, sharing one
// 25x17 multiplier (EMA step, gain, window scale, divide by 100), and the
// two wheels run one after the other.
// A new tick is taken while the previous result still waits in the output
// register; a stalled receiver only holds the block once the next result is
// finished and the output register is still full.
// Reset: ramp, filter and dwell state clear to zero, registers return to
// their defaults, no result is pending and tick is ready.
`default_nettype none

module tank_drive_command_shaper_core (
  input  logic     clk,
  input  logic     rst,
  tdcs_tick_if.sink   tick,
  tdcs_esc_if.source  esc,
  tdcs_cfg_if.sink    cfg
);
  import tdcs_pkg::*;

  cfg_t cfg_q;
  ctl_t ctl;

  assign cfg.ready = 1'b1;

  tdcs_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  tdcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (esc.valid),
    .out_ready (esc.ready),
    .ctl       (ctl)
  );

  tdcs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .cfg            (cfg_q),
    .now_ms         (tick.now_ms),
    .left_target    (tick.left_target),
    .right_target   (tick.right_target),
    .left_esc       (esc.left_esc),
    .right_esc      (esc.right_esc),
    .left_dwelling  (esc.left_dwelling),
    .right_dwelling (esc.right_dwelling)
  );

endmodule

`default_nettype wire

FILE: design/tdcs_cfg_regs.sv
// Configuration register file of the shaper.
`default_nettype none

module tdcs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_valid,
  input  logic [tdcs_pkg::CfgIndexW-1:0] wr_index,
  input  logic [tdcs_pkg::CfgDataW-1:0]  wr_data,
  output tdcs_pkg::cfg_t                cfg
);
  import tdcs_pkg::*;

  cfg_reg_t sel;
  assign sel = cfg_reg_t'(wr_index);

  // Each register keeps the low bits of the written word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step         <= RstRampStep;
      cfg.ema_weight        <= RstAlpha;
      cfg.left_gain         <= RstGain;
      cfg.right_gain        <= RstGain;
      cfg.window_start      <= RstWinStart;
      cfg.window_max        <= RstWinMax;
      cfg.dwell_time        <= RstDwell;
      cfg.reverse_threshold <= RstThreshold;
    end else if (wr_valid) begin
      case (sel)
        REG_RAMP_STEP:    cfg.ramp_step         <= wr_data[7:0];
        REG_EMA_WEIGHT:   cfg.ema_weight        <= wr_data;
        REG_LEFT_GAIN:    cfg.left_gain         <= wr_data;
        REG_RIGHT_GAIN:   cfg.right_gain        <= wr_data;
        REG_WINDOW_START: cfg.window_start      <= wr_data[6:0];
        REG_WINDOW_MAX:   cfg.window_max        <= wr_data[6:0];
        REG_DWELL_TIME:   cfg.dwell_time        <= wr_data;
        REG_REV_THRESH:   cfg.reverse_threshold <= wr_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/tdcs_datapath.sv
// Per-wheel datapath: dwell gate, ramp, EMA, gain and ESC window on one multiplier.
`default_nettype none

module tdcs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tdcs_pkg::ctl_t      ctl,
  input  tdcs_pkg::cfg_t      cfg,
  input  logic [31:0]         now_ms,
  input  logic signed [7:0]   left_target,
  input  logic signed [7:0]   right_target,
  output logic signed [7:0]   left_esc,
  output logic signed [7:0]   right_esc,
  output logic                left_dwelling,
  output logic                right_dwelling
);
  import tdcs_pkg::*;

  // Captured tick
  logic [31:0]       now_r;
  logic signed [7:0] tgt_r [2];

  // Wheel state
  logic signed [7:0]  ramped   [2];
  logic signed [23:0] filt     [2];
  logic               gate_on  [2];
  logic [31:0]        gate_end [2];

  // Working registers
  logic signed [41:0] prod_r;
  logic [23:0]        mag_r;
  logic               mag_neg_r;
  logic signed [7:0]  x_r;
  logic [6:0]         xmag_r;
  logic               pneg_r;
  logic signed [7:0]  esc_r [2];

  logic               w;
  logic signed [7:0]  cur;
  logic signed [7:0]  tgt;
  logic [15:0]        gain;

  logic signed [8:0]  cur9, tgt9, thr9, nthr9;
  logic [31:0]        elapsed;
  logic               held, rev, gate_nx;
  logic signed [9:0]  step10, delta, delta_c, ramp_sum;
  logic signed [7:0]  cur_nx;

  logic signed [24:0] ema_diff;
  logic signed [24:0] ema_abs;
  logic [40:0]        round_sum;
  logic signed [23:0] ema_inc;
  logic signed [23:0] filt_nx;

  logic signed [41:0] bias, biased;
  logic signed [11:0] scaled;
  logic signed [7:0]  x_nx;
  logic signed [7:0]  x_neg;

  logic signed [7:0]  wdiff;
  logic signed [14:0] p15;
  logic signed [14:0] pabs;
  logic signed [9:0]  q10, qs, s10, m10, e10;
  logic [7:0]         emag;
  logic signed [7:0]  esc_nx;

  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] mul_out;

  assign w    = ctl.wheel;
  assign cur  = ramped[w];
  assign tgt  = tgt_r[w];
  assign gain = w ? cfg.right_gain : cfg.left_gain;

  // Reversal gate and slew ramp
  always_comb begin
    cur9    = {cur[7], cur};
    tgt9    = {tgt[7], tgt};
    thr9    = {2'b00, cfg.reverse_threshold};
    nthr9   = -thr9;
    elapsed = now_r - gate_end[w];
    held    = gate_on[w] & elapsed[31];
    rev     = !held && ((cur9 > thr9 && tgt9 < nthr9) || (cur9 < nthr9 && tgt9 > thr9));
    gate_nx = held | rev;
    step10  = {2'b00, cfg.ramp_step};
    delta   = {{2{tgt[7]}}, tgt} - {{2{cur[7]}}, cur};
    if (delta > step10) delta_c = step10;
    else if (delta < -step10) delta_c = -step10;
    else delta_c = delta;
    ramp_sum = {{2{cur[7]}}, cur} + delta_c;
    cur_nx   = gate_nx ? 8'sd0 : ramp_sum[7:0];
  end

  // EMA difference, rounded-up step and filter update
  always_comb begin
    ema_diff  = {cur[7], cur, 16'b0} - {filt[w][23], filt[w]};
    ema_abs   = ema_diff[24] ? -ema_diff : ema_diff;
    round_sum = {1'b0, prod_r[39:0]} + 41'd65535;
    ema_inc   = round_sum[39:16];
    if (cfg.ema_weight == 16'd0) filt_nx = {cur, 16'b0};
    else if (mag_neg_r) filt_nx = filt[w] - ema_inc;
    else filt_nx = filt[w] + ema_inc;
  end

  // Gain scale: truncate toward zero, then clamp
  always_comb begin
    bias   = prod_r[41] ? 42'sh3FFFFFFF : 42'sd0;
    biased = prod_r + bias;
    scaled = biased[41:GainShift];
    if (scaled > 12'sd100) x_nx = CmdLimit;
    else if (scaled < -12'sd100) x_nx = -CmdLimit;
    else x_nx = scaled[7:0];
    x_neg = -x_nx;
  end

  // ESC window
  always_comb begin
    wdiff = {1'b0, cfg.window_max} - {1'b0, cfg.window_start};
    p15   = prod_r[14:0];
    pabs  = p15[14] ? -p15 : p15;
    q10   = {2'b00, prod_r[DivShift+7:DivShift]};
    qs    = pneg_r ? -q10 : q10;
    s10   = {3'b000, cfg.window_start};
    m10   = {3'b000, cfg.window_max};
    e10   = s10 + qs;
    if (e10 < s10) e10 = s10;
    if (e10 > m10) e10 = m10;
    emag  = e10[7:0];
    if (x_r == 8'sd0) esc_nx = 8'sd0;
    else if (x_r[7]) esc_nx = -emag;
    else esc_nx = emag;
  end

  // Shared multiplier operand select
  always_comb begin
    case (ctl.op)
      OP_EMA_MUL: begin
        mul_a = {1'b0, mag_r};
        mul_b = {1'b0, cfg.ema_weight};
      end
      OP_GAIN_MUL: begin
        mul_a = {filt[w][23], filt[w]};
        mul_b = {1'b0, gain};
      end
      OP_WIN_MUL: begin
        mul_a = {{17{wdiff[7]}}, wdiff};
        mul_b = {10'b0, xmag_r};
      end
      OP_DIV_MUL: begin
        mul_a = {10'b0, pabs};
        mul_b = {4'b0, DivRecip};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_out = mul_a * mul_b;
  end

  // Wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        ramped[i]   <= '0;
        filt[i]     <= '0;
        gate_on[i]  <= 1'b0;
        gate_end[i] <= '0;
      end
    end else begin
      case (ctl.op)
        OP_GATE: begin
          ramped[w]  <= cur_nx;
          gate_on[w] <= gate_nx;
          if (rev) gate_end[w] <= now_r + {16'b0, cfg.dwell_time};
        end
        OP_EMA_UPD: filt[w] <= filt_nx;
        default: ;
      endcase
    end
  end

  // Working registers and captured tick
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      now_r    <= now_ms;
      tgt_r[0] <= clamp_cmd(left_target);
      tgt_r[1] <= clamp_cmd(right_target);
    end
    case (ctl.op)
      OP_EMA_DIFF: begin
        mag_r     <= ema_abs[23:0];
        mag_neg_r <= ema_diff[24];
      end
      OP_EMA_MUL, OP_GAIN_MUL, OP_WIN_MUL: prod_r <= mul_out;
      OP_DIV_MUL: begin
        prod_r <= mul_out;
        pneg_r <= p15[14];
      end
      OP_GAIN_SCL: begin
        x_r    <= x_nx;
        xmag_r <= x_nx[7] ? x_neg[6:0] : x_nx[6:0];
      end
      OP_WIN_FIN: esc_r[w] <= esc_nx;
      default: ;
    endcase
  end

  // Output word
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      left_esc       <= esc_r[0];
      right_esc      <= esc_r[1];
      left_dwelling  <= gate_on[0];
      right_dwelling <= gate_on[1];
    end
  end

endmodule

`default_nettype wire

FILE: design/tdcs_ctrl.sv
// Sequencer: walks both wheels through the datapath steps and runs the handshakes.
`default_nettype none

module tdcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tdcs_pkg::ctl_t ctl
);
  import tdcs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_GATE     = 11'b000_0000_0010,
    S_EMA_DIFF = 11'b000_0000_0100,
    S_EMA_MUL  = 11'b000_0000_1000,
    S_EMA_UPD  = 11'b000_0001_0000,
    S_GAIN_MUL = 11'b000_0010_0000,
    S_GAIN_SCL = 11'b000_0100_0000,
    S_WIN_MUL  = 11'b000_1000_0000,
    S_DIV_MUL  = 11'b001_0000_0000,
    S_WIN_FIN  = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic   wheel, wheel_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and step select
  always_comb begin
    state_next   = state;
    wheel_next   = wheel;
    ctl.op       = OP_NONE;
    ctl.wheel    = wheel;
    ctl.load     = 1'b0;
    ctl.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        ctl.load = in_valid;
        if (in_valid) begin
          state_next = S_GATE;
          wheel_next = 1'b0;
        end
      end
      S_GATE: begin
        ctl.op     = OP_GATE;
        state_next = S_EMA_DIFF;
      end
      S_EMA_DIFF: begin
        ctl.op     = OP_EMA_DIFF;
        state_next = S_EMA_MUL;
      end
      S_EMA_MUL: begin
        ctl.op     = OP_EMA_MUL;
        state_next = S_EMA_UPD;
      end
      S_EMA_UPD: begin
        ctl.op     = OP_EMA_UPD;
        state_next = S_GAIN_MUL;
      end
      S_GAIN_MUL: begin
        ctl.op     = OP_GAIN_MUL;
        state_next = S_GAIN_SCL;
      end
      S_GAIN_SCL: begin
        ctl.op     = OP_GAIN_SCL;
        state_next = S_WIN_MUL;
      end
      S_WIN_MUL: begin
        ctl.op     = OP_WIN_MUL;
        state_next = S_DIV_MUL;
      end
      S_DIV_MUL: begin
        ctl.op     = OP_DIV_MUL;
        state_next = S_WIN_FIN;
      end
      S_WIN_FIN: begin
        ctl.op = OP_WIN_FIN;
        if (!wheel) begin
          wheel_next = 1'b1;
          state_next = S_GATE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        ctl.out_load = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wheel     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      wheel <= wheel_next;
      if (ctl.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/tdcs_checker.sv
// Port-level checks of the shaper, bound to the top level.
`default_nettype none
`include "tank_drive_command_shaper_core_defines.svh"

module tdcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] left_esc,
  input logic [7:0] right_esc,
  input logic       left_dwelling,
  input logic       right_dwelling
);

  // After reset the block is idle with nothing pending.
  `TDCS_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, in_ready && !out_valid, "not idle after reset")

  // A taken tick keeps the input closed while it is worked on.
  `TDCS_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready, "ready after take")

  // No result appears right behind a tick.
  `TDCS_ASSERT_NOW(a_no_early_result, clk, rst, $rose(out_valid), !$past(in_valid && in_ready), "result too early")

  // A stalled result word holds.
  `TDCS_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(left_esc) && $stable(right_esc) && $stable(left_dwelling) && $stable(right_dwelling), "stalled word changed")

endmodule

bind tank_drive_command_shaper_core tdcs_checker u_tdcs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (tick.valid),
  .in_ready       (tick.ready),
  .out_valid      (esc.valid),
  .out_ready      (esc.ready),
  .left_esc       (esc.left_esc),
  .right_esc      (esc.right_esc),
  .left_dwelling  (esc.left_dwelling),
  .right_dwelling (esc.right_dwelling)
);

`default_nettype wire
